// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/vlprq_pkg.sv
// Shared types and codes of the packet ring queue.
`default_nettype none
package vlprq_pkg;

  localparam int HEADER_BYTES = 12;

  localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [2:0] OP_PUSH_BYTE = 3'd1;
  localparam logic [2:0] OP_FETCH     = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NO_ROOM  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_ORDER    = 3'd4;

  typedef enum logic [2:0] {
    K_PUSH_HEAD,
    K_PUSH_BYTE,
    K_FETCH,
    K_REMOVE,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  identifier;
    logic [15:0]  length;
    logic [63:0]  timestamp;
    logic [7:0]   data_byte;
    logic         remove_after;
    logic [15:0]  capacity;
    logic [10:0]  remove_count;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/variable_length_packet_ring_queue_core.sv
// Top level of the variable-length packet ring queue.
// Usage:
//   A request is taken at a clock edge with start high and busy low. Requests
//   queue two deep in front of the executing back end, so busy only rises
//   when two requests wait.
//   Each request yields one or more results, each shown for one cycle with
//   done high; last marks the final result of a request. Results of a
//   request come out in order, payload bytes back to back.
//   Steps after the back end picks a request up:
//     push_byte, clear, unused codes: execution, then the result
//     push_head: 12 header byte writes to the ring, then the result; a refusal goes straight to the result
//     fetch: header bytes read from the ring, the header result, then one payload byte per cycle
//     remove: per dropped packet its length read from the ring, then the final result
//   The single ring memory port pair sets these steps.
//   Reset empties the queue and drops any open push; ring contents are
//   kept. The receiver cannot stall, so results are never held back.
`default_nettype none
module variable_length_packet_ring_queue_core import vlprq_pkg::*; #(
  parameter int BUFFER_BYTES      = 1024,
  parameter int MAX_PAYLOAD_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] identifier,
  input  wire logic [15:0] length,
  input  wire logic [63:0] timestamp,
  input  wire logic [7:0]  data_byte,
  input  wire logic        remove_after,
  input  wire logic [15:0] capacity,
  input  wire logic [10:0] remove_count,
  output logic             done,
  output logic [2:0]       status,
  output logic             is_header,
  output logic [15:0]      out_identifier,
  output logic [15:0]      out_length,
  output logic [63:0]      out_timestamp,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic [10:0]      bytes_used,
  output logic [10:0]      packets_held
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  vlprq_front u_front (
    .clk, .rst, .start, .busy, .operation, .identifier, .length, .timestamp,
    .data_byte, .remove_after, .capacity, .remove_count,
    .cmd_valid, .cmd, .cmd_take
  );

  vlprq_back #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .done, .status, .is_header, .out_identifier, .out_length, .out_timestamp,
    .out_byte, .last, .bytes_used, .packets_held
  );

endmodule
`default_nettype wire

// File: rtl/vlprq_front.sv
// Front end: classifies requests and holds them in a two-entry queue.
`default_nettype none
module vlprq_front import vlprq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] identifier,
  input  wire logic [15:0] length,
  input  wire logic [63:0] timestamp,
  input  wire logic [7:0]  data_byte,
  input  wire logic        remove_after,
  input  wire logic [15:0] capacity,
  input  wire logic [10:0] remove_count,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  kind_t      kind;
  logic       push;

  always_comb begin
    case (operation)
      OP_PUSH_HEAD: kind = K_PUSH_HEAD;
      OP_PUSH_BYTE: kind = K_PUSH_BYTE;
      OP_FETCH:     kind = K_FETCH;
      OP_REMOVE:    kind = K_REMOVE;
      OP_CLEAR:     kind = K_CLEAR;
      default:      kind = K_NOP;
    endcase
  end

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, identifier: identifier, length: length,
                     timestamp: timestamp, data_byte: data_byte,
                     remove_after: remove_after, capacity: capacity,
                     remove_count: remove_count};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_take && cmd_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(cmd_take && cmd_valid);
    end
  end

endmodule
`default_nettype wire

// File: rtl/vlprq_back.sv
// Back end: ring memory, pointers and the sequencer that executes requests.
`default_nettype none
module vlprq_back import vlprq_pkg::*; #(
  parameter int BUFFER_BYTES      = 1024,
  parameter int MAX_PAYLOAD_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_take,
  output logic             done,
  output logic [2:0]       status,
  output logic             is_header,
  output logic [15:0]      out_identifier,
  output logic [15:0]      out_length,
  output logic [63:0]      out_timestamp,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic [10:0]      bytes_used,
  output logic [10:0]      packets_held
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int LW = $clog2(MAX_PAYLOAD_BYTES + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HWR  = 8'b0000_0010,
    S_HRD  = 8'b0000_0100,
    S_HDR  = 8'b0000_1000,
    S_PAY  = 8'b0001_0000,
    S_RM   = 8'b0010_0000,
    S_DROP = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_t;

  state_t         state;
  logic [7:0]     ram [BUFFER_BYTES];
  logic [7:0]     rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [7:0]     mem_wd;
  logic [AW-1:0]  mem_ra;

  logic [PW-1:0]  rp, wp, ep, used, pc;
  logic [LW-1:0]  pend, olen, pidx, plen_q;
  logic [PW-1:0]  base;
  logic [3:0]     idx;
  logic [7:0]     hb [HEADER_BYTES];
  logic [95:0]    wr_hdr;
  logic [LW-1:0]  new_len;
  logic [10:0]    cnt;
  logic           is_rm;
  logic           pop;
  logic [15:0]    cap;
  logic [2:0]     st_q;

  // header view and derived values
  logic [15:0]    plen;
  logic [17:0]    hsize;
  logic           give;
  logic [PW:0]    need;
  logic [PW:0]    olsize;
  logic [3:0]     rd_end;

  assign plen   = {hb[1], hb[0]};
  assign hsize  = 18'(plen) + 18'(HEADER_BYTES);
  assign give   = (plen != 16'd0) && (cap >= plen) &&
                  (plen <= 16'(MAX_PAYLOAD_BYTES));
  assign need   = (PW+1)'(HEADER_BYTES) + (PW+1)'(cmd.length[LW-1:0]);
  assign olsize = (PW+1)'(HEADER_BYTES) + (PW+1)'(olen);
  assign rd_end = is_rm ? 4'd2 : 4'(HEADER_BYTES);
  assign cmd_take = (state == S_IDLE) && cmd_valid;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wp[AW-1:0];
    mem_wd = cmd.data_byte;
    mem_ra = base[AW-1:0];
    case (state)
      S_IDLE: begin
        mem_we = cmd_valid && (cmd.kind == K_PUSH_BYTE) && (pend != '0);
        mem_wa = AW'(wp + PW'(HEADER_BYTES) + PW'(olen - pend));
      end
      S_HWR: begin
        mem_we = 1'b1;
        mem_wa = AW'(base + PW'(idx));
        mem_wd = wr_hdr[idx*8 +: 8];
      end
      S_HRD:   mem_ra = AW'(base + PW'(idx));
      S_HDR:   mem_ra = AW'(base + PW'(HEADER_BYTES));
      S_PAY:   mem_ra = AW'(base + PW'(HEADER_BYTES) + PW'(pidx) + PW'(1));
      default: mem_ra = base[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) ram[mem_wa] <= mem_wd;
    rdata <= ram[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_HRD && idx != 4'd0) hb[idx - 4'd1] <= rdata;
    if (rst) begin
      state <= S_IDLE;
      rp <= '0; wp <= '0; ep <= '0; used <= '0; pc <= '0;
      pend <= '0; olen <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            st_q <= ST_OK;
            state <= S_RES;
            case (cmd.kind)
              K_PUSH_HEAD: begin
                pend <= '0;
                olen <= '0;
                wr_hdr  <= {cmd.timestamp, cmd.identifier, cmd.length};
                new_len <= cmd.length[LW-1:0];
                idx <= 4'd0;
                if (cmd.length > 16'(MAX_PAYLOAD_BYTES)) begin
                  st_q <= ST_TOO_LONG;
                end else if (wp == ep &&
                             ((PW+1)'(wp) + need > (PW+1)'(BUFFER_BYTES))) begin
                  // tail too short: wrap to address 0 if there is room before the read pointer
                  if ((PW+1)'(rp) < need) begin
                    st_q <= ST_NO_ROOM;
                  end else begin
                    wp <= '0;
                    base <= '0;
                    if (rp == ep) begin
                      rp <= '0;
                      ep <= '0;
                    end
                    state <= S_HWR;
                  end
                end else if (wp < ep && ((PW+1)'(wp) + need >= (PW+1)'(rp))) begin
                  st_q <= ST_NO_ROOM;
                end else begin
                  base <= wp;
                  state <= S_HWR;
                end
              end
              K_PUSH_BYTE: begin
                if (pend == '0) begin
                  st_q <= ST_ORDER;
                end else begin
                  pend <= pend - LW'(1);
                  if (pend == LW'(1)) begin
                    pc   <= pc + PW'(1);
                    used <= used + PW'(olsize);
                    wp   <= wp + PW'(olsize);
                    if (wp + PW'(olsize) > ep) ep <= wp + PW'(olsize);
                    olen <= '0;
                  end
                end
              end
              K_FETCH: begin
                pop <= cmd.remove_after;
                cap <= cmd.capacity;
                is_rm <= 1'b0;
                idx <= 4'd0;
                if (pc == '0 || used == '0) begin
                  st_q <= ST_EMPTY;
                end else begin
                  state <= S_HRD;
                  if (rp == ep) begin
                    rp <= '0;
                    ep <= wp;
                    base <= '0;
                  end else begin
                    base <= rp;
                  end
                end
              end
              K_REMOVE: begin
                cnt <= (PW'(cmd.remove_count) > pc) ? 11'(pc) : cmd.remove_count;
                state <= S_RM;
              end
              K_CLEAR: begin
                rp <= '0; wp <= '0; ep <= '0; used <= '0; pc <= '0;
                pend <= '0; olen <= '0;
              end
              default: ;
            endcase
          end
        end
        S_HWR: begin
          idx <= idx + 4'd1;
          if (idx == 4'(HEADER_BYTES - 1)) begin
            olen <= new_len;
            pend <= new_len;
            if (new_len == '0) begin
              // empty payload commits at once
              pc   <= pc + PW'(1);
              used <= used + PW'(HEADER_BYTES);
              wp   <= wp + PW'(HEADER_BYTES);
              if (wp + PW'(HEADER_BYTES) > ep) ep <= wp + PW'(HEADER_BYTES);
            end
            state <= S_RES;
          end
        end
        S_HRD: begin
          idx <= idx + 4'd1;
          if (idx == rd_end) state <= is_rm ? S_DROP : S_HDR;
        end
        S_HDR: begin
          done <= 1'b1;
          status <= ST_OK;
          is_header <= 1'b1;
          out_identifier <= {hb[3], hb[2]};
          out_length <= (cap >= plen) ? plen : 16'd0;
          out_timestamp <= {hb[11], hb[10], hb[9], hb[8], hb[7], hb[6], hb[5], hb[4]};
          out_byte <= 8'd0;
          last <= !give;
          plen_q <= plen[LW-1:0];
          pidx <= '0;
          if (pop) begin
            if (pc != '0) pc <= pc - PW'(1);
            used <= (18'(used) >= hsize) ? used - PW'(hsize) : '0;
            rp <= rp + PW'(hsize);
          end
          state <= give ? S_PAY : S_IDLE;
          bytes_used   <= 11'(pop ? ((18'(used) >= hsize) ? used - PW'(hsize) : '0) : used);
          packets_held <= 11'(pop && pc != '0 ? pc - PW'(1) : pc);
        end
        S_PAY: begin
          done <= 1'b1;
          is_header <= 1'b0;
          out_identifier <= 16'd0;
          out_length <= 16'd0;
          out_timestamp <= 64'd0;
          out_byte <= rdata;
          last <= (pidx + LW'(1) == plen_q);
          pidx <= pidx + LW'(1);
          if (pidx + LW'(1) == plen_q) state <= S_IDLE;
        end
        S_RM: begin
          if (cnt == 11'd0 || used == '0 || pc == '0) begin
            state <= S_RES;
          end else begin
            is_rm <= 1'b1;
            idx <= 4'd0;
            state <= S_HRD;
            if (rp == ep) begin
              rp <= '0;
              ep <= wp;
              base <= '0;
            end else begin
              base <= rp;
            end
          end
        end
        S_DROP: begin
          if (pc != '0) pc <= pc - PW'(1);
          used <= (18'(used) >= hsize) ? used - PW'(hsize) : '0;
          rp <= rp + PW'(hsize);
          cnt <= cnt - 11'd1;
          state <= S_RM;
        end
        S_RES: begin
          done <= 1'b1;
          status <= st_q;
          is_header <= 1'b0;
          out_identifier <= 16'd0;
          out_length <= 16'd0;
          out_timestamp <= 64'd0;
          out_byte <= 8'd0;
          last <= 1'b1;
          bytes_used <= 11'(used);
          packets_held <= 11'(pc);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/vlprq_checker.sv
// Port-level checks of the packet ring queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module vlprq_checker import vlprq_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic       is_header,
  input wire logic       last
);

  `ASSERT_ALWAYS(a_quiet_after_reset, clk, rst |=> !done, "result right after reset")
  `ASSERT_CLK(a_header_ok, clk, rst, done && is_header |-> status == ST_OK, "header with error")
  `ASSERT_CLK(a_error_single, clk, rst, done && status != ST_OK |-> last && !is_header, "error not single")
  `ASSERT_CLK(a_payload_after, clk, rst, done && !is_header && !last && status == ST_OK |=> done && !is_header, "payload gap")

endmodule

bind variable_length_packet_ring_queue_core vlprq_checker u_checker (
  .clk(clk), .rst(rst), .done(done), .status(status),
  .is_header(is_header), .last(last)
);
`default_nettype wire
